// ----- sv/hvd_pkg.sv -----
// Shared constants, types and elaboration-time table functions for the
// haversine distance pipeline. No dependencies.
`default_nettype none

package hvd_pkg;

  // Number formats
  localparam int ANGLE_FRAC_BITS   = 24;
  localparam int CORDIC_ITERATIONS = 28;
  localparam int VEC_SCALE         = 24;
  localparam int SQRT_STEPS        = 32;

  // Field widths
  localparam int LAT_W  = 32;
  localparam int LON_W  = 33;
  localparam int RAD_W  = 23;
  localparam int DIST_W = 33;

  // Internal widths
  localparam int RW  = 34;                   // angle magnitude before folding
  localparam int RN  = ANGLE_FRAC_BITS + 8;  // folded angle, at most half a turn
  localparam int ZW  = 40;                   // CORDIC angle accumulator, Q32 radians
  localparam int CW  = 40;                   // rotation CORDIC vector, Q32
  localparam int VW  = 60;                   // vectoring CORDIC vector
  localparam int MW  = 33;                   // clamped magnitude, up to 1.0 in Q32
  localparam int AW  = 63;                   // a in Q62, up to 1.0
  localparam int SW  = SQRT_STEPS;           // square root result width
  localparam int RESW = 64;                  // square root working remainder
  localparam int HW  = 34;                   // central half angle, unsigned

  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG2RAD_Q62 = PI_Q60 / 64'd45;
  localparam logic [63:0] ONE_Q62     = 64'd1 << 62;
  localparam logic [MW-1:0] ONE_Q32   = MW'(64'd1 << 32);

  localparam logic [RW-1:0] FULL_TURN = RW'(64'd360 << ANGLE_FRAC_BITS);
  localparam logic [RW-1:0] HALF_TURN = RW'(64'd180 << ANGLE_FRAC_BITS);
  localparam logic [RW-1:0] QTR_TURN  = RW'(64'd90 << ANGLE_FRAC_BITS);

  localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(6371000);
  localparam logic [DIST_W-1:0] DIST_MAX     = DIST_W'(64'd6746518144);

  // Stage payloads between modules
  typedef struct packed {
    logic [3:0][ZW-1:0] z;   // lanes: half dlat, half dlon, lat a, lat b
    logic               n1;  // lat a folded past a quarter turn
    logic               n2;  // lat b folded past a quarter turn
  } rot_in_t;

  typedef struct packed {
    logic [3:0][CW-1:0] x;
    logic [3:0][CW-1:0] y;
    logic               n1;
    logic               n2;
  } rot_out_t;

  typedef struct packed {
    logic [AW-1:0] a;
    logic [AW-1:0] b;        // 1 - a
  } sq_in_t;

  typedef struct packed {
    logic [SW-1:0] sa;
    logic [SW-1:0] ca;
  } sq_out_t;

  // unsigned quotient by restoring long division, for table building
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctan(2^-i) in Q32, from the odd power series in Q62, rounded
  function automatic logic [63:0] atan_calc(input int i);
    logic signed [63:0] t;
    logic [63:0]        term;
    int                 e;
    t = '0;
    if (i == 0) begin
      t = PI_Q60;
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = udiv(ONE_Q62 >> e, 64'(2 * k + 1));
          t = k[0] ? t - term : t + term;
        end
      end
    end
    return (t + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Inverse CORDIC gain in Q32
  function automatic logic [63:0] gain_calc();
    logic [63:0] g;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    g = 64'd1 << 60;
    for (int i = 0; i < CORDIC_ITERATIONS && i < 64; i++) begin
      if (2 * i <= 60) g = g + (g >> (2 * i));
    end
    v   = g;
    res = '0;
    bt  = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bt != 0) begin
        if (v >= res + bt) begin
          v   = v - res - bt;
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return udiv(ONE_Q62, res);
  endfunction

endpackage

`default_nettype wire

// ----- sv/hvd_if.sv -----
// Channel interfaces of the haversine distance block: point pairs in,
// distances out, radius writes. Depends on hvd_pkg.
`default_nettype none

interface hvd_point_if import hvd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] latitude_a;
  logic signed [LON_W-1:0] longitude_a;
  logic signed [LAT_W-1:0] latitude_b;
  logic signed [LON_W-1:0] longitude_b;
  modport source (output valid, latitude_a, longitude_a, latitude_b, longitude_b,
                  input ready);
  modport sink   (input valid, latitude_a, longitude_a, latitude_b, longitude_b,
                  output ready);
endinterface

interface hvd_dist_if import hvd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

interface hvd_cfg_if import hvd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAD_W-1:0] sphere_radius_m;
  modport source (output valid, sphere_radius_m, input ready);
  modport sink   (input valid, sphere_radius_m, output ready);
endinterface

`default_nettype wire

// ----- sv/hvd_front.sv -----
// Front end: coordinate differences, reduction modulo a turn, folding and
// conversion of degrees to Q32 radians. Depends on hvd_pkg.
`default_nettype none

module hvd_front import hvd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [LAT_W-1:0] latitude_a,
  input  logic signed [LON_W-1:0] longitude_a,
  input  logic signed [LAT_W-1:0] latitude_b,
  input  logic signed [LON_W-1:0] longitude_b,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rot_in_t                 out_data
);

  localparam int NS = 5;
  localparam logic [RN+31:0] K_HI = (RN+32)'(DEG2RAD_Q62[63:32]);
  localparam logic [RN+31:0] K_LO = (RN+32)'(DEG2RAD_Q62[31:0]);

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  logic signed [LAT_W:0]   d_lat;
  logic signed [LON_W:0]   d_lon;
  logic signed [LAT_W-1:0] la;
  logic signed [LAT_W-1:0] lb;
  logic [RW-1:0]           r1 [4];
  logic [RN-1:0]           r2 [4];
  logic [RN-1:0]           r2_next [4];
  logic [RN+31:0]          pp_hi [4];
  logic [RN+31:0]          pp_lo [4];
  logic [1:0]              nf2, nf3, nf4;
  logic [1:0]              nf_next;
  logic [ZW-1:0]           z4 [4];

  // magnitude reduced into one turn; inputs stay below two turns
  function automatic logic [RW-1:0] mod_turn(input logic signed [RW:0] v);
    logic [RW:0] m;
    m = (v < 0) ? (RW+1)'(-v) : (RW+1)'(v);
    return (m >= {1'b0, FULL_TURN}) ? RW'(m - {1'b0, FULL_TURN}) : RW'(m);
  endfunction

  // bubble-collapsing handshake
  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~vld[k] | rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 0: differences
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      d_lat <= (LAT_W+1)'(latitude_b) - (LAT_W+1)'(latitude_a);
      d_lon <= (LON_W+1)'(longitude_b) - (LON_W+1)'(longitude_a);
      la    <= latitude_a;
      lb    <= latitude_b;
    end
  end

  // stage 1: magnitude modulo a full turn
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      r1[0] <= mod_turn((RW+1)'(d_lat));
      r1[1] <= mod_turn((RW+1)'(d_lon));
      r1[2] <= mod_turn((RW+1)'(la));
      r1[3] <= mod_turn((RW+1)'(lb));
    end
  end

  // stage 2: fold to half a turn, latitudes to a quarter turn
  always_comb begin
    logic [RW-1:0] f;
    nf_next = '0;
    for (int k = 0; k < 4; k++) begin
      f = (r1[k] > HALF_TURN) ? FULL_TURN - r1[k] : r1[k];
      if (k >= 2 && f > QTR_TURN) begin
        f = HALF_TURN - f;
        nf_next[k-2] = 1'b1;
      end
      r2_next[k] = RN'(f);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      r2  <= r2_next;
      nf2 <= nf_next;
    end
  end

  // stage 3: partial products with the degree-to-radian constant
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int k = 0; k < 4; k++) begin
        pp_hi[k] <= (RN+32)'(r2[k]) * K_HI;
        pp_lo[k] <= (RN+32)'(r2[k]) * K_LO;
      end
      nf3 <= nf2;
    end
  end

  // stage 4: sum partials; half angles take one more bit of shift
  always_ff @(posedge clk) begin
    logic [RN+63:0] s;
    if (rdy[4]) begin
      for (int k = 0; k < 4; k++) begin
        s = {pp_hi[k], 32'b0} + (RN+64)'(pp_lo[k]);
        z4[k] <= (k < 2) ? ZW'(s >> (ANGLE_FRAC_BITS + 31))
                         : ZW'(s >> (ANGLE_FRAC_BITS + 30));
      end
      nf4 <= nf3;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) out_data.z[k] = z4[k];
    out_data.n1 = nf4[0];
    out_data.n2 = nf4[1];
  end

endmodule

`default_nettype wire

// ----- sv/hvd_rotate.sv -----
// Four-lane rotation CORDIC, one iteration per register stage, giving
// sine and cosine in Q32. Depends on hvd_pkg.
`default_nettype none

module hvd_rotate import hvd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  rot_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rot_out_t out_data
);

  localparam int NS = CORDIC_ITERATIONS;
  localparam logic signed [CW-1:0] GAIN = CW'(gain_calc());

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  logic signed [CW-1:0] xs [NS][4];
  logic signed [CW-1:0] ys [NS][4];
  logic signed [ZW-1:0] zs [NS][4];
  logic [1:0]           fs [NS];

  // shift toward zero, as the iteration requires
  function automatic logic signed [CW-1:0] sshr(input logic signed [CW-1:0] v, input int s);
    return (v < 0) ? -((-v) >>> s) : (v >>> s);
  endfunction

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~vld[k] | rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // iteration stages
  for (genvar i = 0; i < NS; i++) begin : g_it
    localparam logic signed [ZW-1:0] AT = ZW'(atan_calc(i));
    logic signed [CW-1:0] cx [4];
    logic signed [CW-1:0] cy [4];
    logic signed [ZW-1:0] cz [4];
    logic [1:0]           cf;

    if (i == 0) begin : g_src
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          cx[k] = GAIN;
          cy[k] = '0;
          cz[k] = $signed(in_data.z[k]);
        end
        cf = {in_data.n2, in_data.n1};
      end
    end else begin : g_src
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          cx[k] = xs[i-1][k];
          cy[k] = ys[i-1][k];
          cz[k] = zs[i-1][k];
        end
        cf = fs[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        for (int k = 0; k < 4; k++) begin
          if (cz[k] >= 0) begin
            xs[i][k] <= cx[k] - sshr(cy[k], i);
            ys[i][k] <= cy[k] + sshr(cx[k], i);
            zs[i][k] <= cz[k] - AT;
          end else begin
            xs[i][k] <= cx[k] + sshr(cy[k], i);
            ys[i][k] <= cy[k] - sshr(cx[k], i);
            zs[i][k] <= cz[k] + AT;
          end
        end
        fs[i] <= cf;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      out_data.x[k] = xs[NS-1][k];
      out_data.y[k] = ys[NS-1][k];
    end
    out_data.n1 = fs[NS-1][0];
    out_data.n2 = fs[NS-1][1];
  end

endmodule

`default_nettype wire

// ----- sv/hvd_square.sv -----
// Haversine term a = sin^2(dlat/2) + cos*cos*sin^2(dlon/2), multiplies in
// stages 1 to 3, clamped to [0,1] in Q62, plus 1 - a. Depends on hvd_pkg.
`default_nettype none

module hvd_square import hvd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  rot_out_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sq_in_t   out_data
);

  localparam int NS = 6;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  logic [MW-1:0]   s1, s2, m1, m2;
  logic            neg0, neg1, neg2, neg3;
  logic [AW-1:0]   sq1, sq2, sq3;
  logic [MW-1:0]   s2_1, s2_2;
  logic [MW-1:0]   mm;
  logic [MW-1:0]   u;
  logic [AW-1:0]   t;
  logic [AW-1:0]   a4;
  logic [AW-1:0]   a5, b5;
  logic [2*MW-1:0] p_sq, p_mm, p_u, p_t;

  // magnitude clamped to 1.0 in Q32
  function automatic logic [MW-1:0] mag32(input logic signed [CW-1:0] v);
    logic [CW-1:0] m;
    m = (v < 0) ? CW'(-v) : CW'(v);
    return (m > CW'(ONE_Q32)) ? ONE_Q32 : MW'(m);
  endfunction

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~vld[k] | rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 0: magnitudes and sign of the cosine product
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1   <= mag32($signed(in_data.y[0]));
      s2   <= mag32($signed(in_data.y[1]));
      m1   <= mag32($signed(in_data.x[2]));
      m2   <= mag32($signed(in_data.x[3]));
      neg0 <= (in_data.n1 ^ in_data.x[2][CW-1]) ^ (in_data.n2 ^ in_data.x[3][CW-1]);
    end
  end

  assign p_sq = (2*MW)'(s1) * (2*MW)'(s1);
  assign p_mm = (2*MW)'(m1) * (2*MW)'(m2);
  assign p_u  = (2*MW)'(mm) * (2*MW)'(s2_1);
  assign p_t  = (2*MW)'(u) * (2*MW)'(s2_2);

  // stages 1 to 3: product chain
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sq1  <= p_sq[AW+1:2];
      mm   <= p_mm[MW+31:32];
      s2_1 <= s2;
      neg1 <= neg0;
    end
    if (rdy[2]) begin
      u    <= p_u[MW+31:32];
      s2_2 <= s2_1;
      sq2  <= sq1;
      neg2 <= neg1;
    end
    if (rdy[3]) begin
      t    <= p_t[AW+1:2];
      sq3  <= sq2;
      neg3 <= neg2;
    end
  end

  // stage 4: combine and clamp; stage 5: complement
  always_ff @(posedge clk) begin
    logic [AW:0] sum;
    if (rdy[4]) begin
      sum = (AW+1)'(sq3) + (AW+1)'(t);
      if (neg3) begin
        a4 <= (sq3 > t) ? sq3 - t : '0;
      end else begin
        a4 <= (sum > (AW+1)'(ONE_Q62)) ? AW'(ONE_Q62) : AW'(sum);
      end
    end
    if (rdy[5]) begin
      a5 <= a4;
      b5 <= AW'(ONE_Q62) - a4;
    end
  end

  assign out_data.a = a5;
  assign out_data.b = b5;

endmodule

`default_nettype wire

// ----- sv/hvd_sqrt.sv -----
// Two-lane digit-by-digit integer square root, one result bit per
// register stage: sqrt(a) and sqrt(1-a) in Q31. Depends on hvd_pkg.
`default_nettype none

module hvd_sqrt import hvd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sq_in_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output sq_out_t out_data
);

  localparam int NS = SQRT_STEPS;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  logic [AW-1:0]   vs [NS][2];
  logic [RESW-1:0] rs [NS][2];

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~vld[k] | rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // one trial subtraction per stage
  for (genvar j = 0; j < NS; j++) begin : g_st
    localparam logic [RESW-1:0] BIT = RESW'(64'd1 << (2 * (NS - 1 - j)));
    logic [AW-1:0]   cv [2];
    logic [RESW-1:0] cr [2];

    if (j == 0) begin : g_src
      always_comb begin
        cv[0] = in_data.a;
        cv[1] = in_data.b;
        cr[0] = '0;
        cr[1] = '0;
      end
    end else begin : g_src
      always_comb begin
        for (int k = 0; k < 2; k++) begin
          cv[k] = vs[j-1][k];
          cr[k] = rs[j-1][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      logic [RESW-1:0] cand;
      if (rdy[j]) begin
        for (int k = 0; k < 2; k++) begin
          cand = cr[k] + BIT;
          if (RESW'(cv[k]) >= cand) begin
            vs[j][k] <= cv[k] - AW'(cand);
            rs[j][k] <= (cr[k] >> 1) + BIT;
          end else begin
            vs[j][k] <= cv[k];
            rs[j][k] <= cr[k] >> 1;
          end
        end
      end
    end
  end

  assign out_data.sa = rs[NS-1][0][SW-1:0];
  assign out_data.ca = rs[NS-1][1][SW-1:0];

endmodule

`default_nettype wire

// ----- sv/hvd_vector.sv -----
// Vectoring CORDIC, one iteration per register stage: the half central
// angle atan2(sqrt(a), sqrt(1-a)) in Q32. Depends on hvd_pkg.
`default_nettype none

module hvd_vector import hvd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sq_out_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [ZW-1:0] angle
);

  localparam int NS = CORDIC_ITERATIONS;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  logic signed [VW-1:0] xs [NS];
  logic signed [VW-1:0] ys [NS];
  logic signed [ZW-1:0] zs [NS];

  function automatic logic signed [VW-1:0] sshr(input logic signed [VW-1:0] v, input int s);
    return (v < 0) ? -((-v) >>> s) : (v >>> s);
  endfunction

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~vld[k] | rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_it
    localparam logic signed [ZW-1:0] AT = ZW'(atan_calc(i));
    logic signed [VW-1:0] cx;
    logic signed [VW-1:0] cy;
    logic signed [ZW-1:0] cz;

    if (i == 0) begin : g_src
      // square roots scaled up for headroom in the shifts
      assign cx = VW'(in_data.ca) <<< VEC_SCALE;
      assign cy = VW'(in_data.sa) <<< VEC_SCALE;
      assign cz = '0;
    end else begin : g_src
      assign cx = xs[i-1];
      assign cy = ys[i-1];
      assign cz = zs[i-1];
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        if (cy > 0) begin
          xs[i] <= cx + sshr(cy, i);
          ys[i] <= cy - sshr(cx, i);
          zs[i] <= cz + AT;
        end else begin
          xs[i] <= cx - sshr(cy, i);
          ys[i] <= cy + sshr(cx, i);
          zs[i] <= cz - AT;
        end
      end
    end
  end

  assign angle = zs[NS-1];

endmodule

`default_nettype wire

// ----- sv/haversine_distance.sv -----
// Top level of the haversine great-circle distance pipeline: radius
// register, final scaling and output register. Depends on hvd_pkg,
// hvd_if, hvd_front, hvd_rotate, hvd_square, hvd_sqrt, hvd_vector.
//
//   channel  dir  beat carries
//   point    in   latitude_a, longitude_a, latitude_b, longitude_b
//   result   out  distance (meters * 2^8, saturating)
//   cfg      in   sphere_radius_m (always ready)
//
// One point pair per cycle unless the output stalls; 5 front-end stages, 28
// rotation CORDIC stages, 6 multiply stages, 32 square root stages,
// 28 vectoring CORDIC stages and 2 scaling stages.
// Each stage holds its beat only while the next one is full, so bubbles
// collapse and a stalled output still lets new pairs in.
// Synchronous reset empties the pipeline and sets the radius to 6371000 m.
`default_nettype none

module haversine_distance import hvd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  hvd_point_if.sink    point,
  hvd_dist_if.source   result,
  hvd_cfg_if.sink      cfg
);

  logic                 fr_valid, fr_ready;
  rot_in_t              fr_data;
  logic                 ro_valid, ro_ready;
  rot_out_t             ro_data;
  logic                 sq_valid, sq_ready;
  sq_in_t               sq_data;
  logic                 rt_valid, rt_ready;
  sq_out_t              rt_data;
  logic                 ve_valid, ve_ready;
  logic signed [ZW-1:0] ve_angle;

  logic [RAD_W-1:0]      radius;
  logic                  vq0, vq1;
  logic                  rdy_q0, rdy_q1;
  logic [RAD_W+HW-1:0]   prod;
  logic [HW-1:0]         h;
  logic [DIST_W-1:0]     distance;
  logic [DIST_W-1:0]     distance_next;
  logic [RAD_W+HW:0]     rounded;

  // radius register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg.valid) begin
      radius <= cfg.sphere_radius_m;
    end
  end

  hvd_front u_front (
    .clk, .rst,
    .in_valid    (point.valid),
    .in_ready    (point.ready),
    .latitude_a  (point.latitude_a),
    .longitude_a (point.longitude_a),
    .latitude_b  (point.latitude_b),
    .longitude_b (point.longitude_b),
    .out_valid   (fr_valid),
    .out_ready   (fr_ready),
    .out_data    (fr_data)
  );

  hvd_rotate u_rotate (
    .clk, .rst,
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (ro_valid),
    .out_ready (ro_ready),
    .out_data  (ro_data)
  );

  hvd_square u_square (
    .clk, .rst,
    .in_valid  (ro_valid),
    .in_ready  (ro_ready),
    .in_data   (ro_data),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_data  (sq_data)
  );

  hvd_sqrt u_sqrt (
    .clk, .rst,
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_data   (sq_data),
    .out_valid (rt_valid),
    .out_ready (rt_ready),
    .out_data  (rt_data)
  );

  hvd_vector u_vector (
    .clk, .rst,
    .in_valid  (rt_valid),
    .in_ready  (rt_ready),
    .in_data   (rt_data),
    .out_valid (ve_valid),
    .out_ready (ve_ready),
    .angle     (ve_angle)
  );

  // scaling stages handshake
  assign rdy_q1   = ~vq1 | result.ready;
  assign rdy_q0   = ~vq0 | rdy_q1;
  assign ve_ready = rdy_q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq0 <= 1'b0;
      vq1 <= 1'b0;
    end else begin
      if (rdy_q0) vq0 <= ve_valid;
      if (rdy_q1) vq1 <= vq0;
    end
  end

  // q0: radius times the half angle (a negative angle counts as zero)
  assign h = ve_angle[ZW-1] ? '0 : ve_angle[HW-1:0];
  always_ff @(posedge clk) begin
    if (rdy_q0) prod <= (RAD_W+HW)'(radius) * (RAD_W+HW)'(h);
  end

  // q1: round half up to meters * 2^8, saturate
  assign rounded = (RAD_W+HW+1)'(prod) + (RAD_W+HW+1)'(64'd1 << 22);
  assign distance_next = (rounded[RAD_W+HW:23] > (RAD_W+HW-22)'(DIST_MAX)) ?
                         DIST_MAX : rounded[DIST_W+22:23];
  always_ff @(posedge clk) begin
    if (rdy_q1) distance <= distance_next;
  end

  assign result.valid    = vq1;
  assign result.distance = distance;

`ifndef ASSERT_OFF
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> point.ready)
    else $error("input stalled with an empty output stage");
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.distance <= DIST_MAX))
    else $error("distance beyond saturation limit");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire
